// ----- rtl/core/rrf_pkg.sv -----
package rrf_pkg;

   localparam int unsigned SlotCount = 8;
   localparam int unsigned SlotCountWidth = 4;

   localparam logic [7:0] EscByte = 8'hC0;
   localparam logic [7:0] StartByte = 8'hC1;
   localparam logic [7:0] MarkC2Byte = 8'hC2;

   localparam logic [15:0] CrcPoly = 16'h8408;
   localparam logic [15:0] CrcInit = 16'hFFFF;

   localparam logic [7:0] CsrDeviceType = 8'd0;
   localparam logic [7:0] CsrLineAddress = 8'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic       frame_end;
      logic [7:0] service_byte;
      logic [7:0] body_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_last;
   } rsp_type;

   // Unescaped bytes of one request; slot 0 goes out first.
   typedef struct packed {
      logic [SlotCount-1:0][7:0]  bytes;
      logic [SlotCount-1:0]       raw;
      logic [SlotCountWidth-1:0]  count;
      logic                       end_frame;
   } batch_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int j = 0; j < 8; j++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   localparam logic [15:0] CrcAfterStart = crc_byte(CrcInit, StartByte);

endpackage

// ----- rtl/core/rrf_builder.sv -----
module rrf_builder (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  rrf_pkg::req_type    req_payload,
   input  logic [7:0]          device_type,
   input  logic [7:0]          line_address,
   input  logic                take,
   output logic                batch_valid,
   output rrf_pkg::batch_type  batch
);

   logic               in_frame_ff, in_frame_in;
   logic [15:0]        crc_ff, crc_in;
   logic               batch_valid_ff, batch_valid_in;
   rrf_pkg::batch_type batch_ff, batch_in;
   logic               active;
   logic [15:0]        c1, c2, c3, c4, base, c5;

   always_comb begin
      active = req_payload.frame_start || in_frame_ff;
      c1 = rrf_pkg::crc_byte(rrf_pkg::CrcAfterStart, device_type);
      c2 = rrf_pkg::crc_byte(c1, line_address);
      c3 = rrf_pkg::crc_byte(c2, req_payload.service_byte);
      c4 = rrf_pkg::crc_byte(c3, req_payload.body_length);
      base = req_payload.frame_start ? c4 : crc_ff;
      c5 = rrf_pkg::crc_byte(base, req_payload.data_byte);

      batch_in = '0;
      batch_in.end_frame = req_payload.frame_end;
      if (req_payload.frame_start) begin
         batch_in.bytes[0] = rrf_pkg::StartByte;
         batch_in.bytes[1] = device_type;
         batch_in.bytes[2] = line_address;
         batch_in.bytes[3] = req_payload.service_byte;
         batch_in.bytes[4] = req_payload.body_length;
         batch_in.bytes[5] = req_payload.data_byte;
         batch_in.bytes[6] = c5[7:0];
         batch_in.bytes[7] = c5[15:8];
         batch_in.raw[0] = 1'b1;
         batch_in.count = req_payload.frame_end ? 4'd8 : 4'd6;
      end else begin
         batch_in.bytes[0] = req_payload.data_byte;
         batch_in.bytes[1] = c5[7:0];
         batch_in.bytes[2] = c5[15:8];
         batch_in.count = req_payload.frame_end ? 4'd3 : 4'd1;
      end

      in_frame_in = in_frame_ff;
      crc_in = crc_ff;
      if (accept && active) begin
         if (req_payload.frame_end) begin
            in_frame_in = 1'b0;
            crc_in = rrf_pkg::CrcInit;
         end else begin
            in_frame_in = 1'b1;
            crc_in = c5;
         end
      end

      batch_valid_in = batch_valid_ff && !take;
      if (accept && active) begin
         batch_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         crc_ff <= rrf_pkg::CrcInit;
         batch_valid_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         crc_ff <= crc_in;
         batch_valid_ff <= batch_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && active) begin
         batch_ff <= batch_in;
      end
   end

   assign batch_valid = batch_valid_ff;
   assign batch = batch_ff;

   // A held batch must not be overwritten before the emitter takes it.
   a_batch_hold: assert property (@(posedge clock) disable iff (reset)
      batch_valid_ff && !take |=> batch_valid_ff && $stable(batch_ff))
      else $error("pending batch lost or changed");

   a_batch_nonempty: assert property (@(posedge clock) disable iff (reset)
      batch_valid_ff |-> batch_ff.count != 4'd0)
      else $error("empty batch marked valid");

endmodule

// ----- rtl/core/rrf_emitter.sv -----
module rrf_emitter (
   input  logic                clock,
   input  logic                reset,
   input  logic                batch_valid,
   input  rrf_pkg::batch_type  batch,
   output logic                take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rrf_pkg::rsp_type    rsp_payload
);

   logic [rrf_pkg::SlotCount-1:0][7:0]   bytes_ff, bytes_in;
   logic [rrf_pkg::SlotCount-1:0]        raw_ff, raw_in;
   logic [rrf_pkg::SlotCountWidth-1:0]   remain_ff, remain_in;
   logic                                 end_ff, end_in;
   logic                                 phase_ff, phase_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   rrf_pkg::rsp_type                     rsp_ff, rsp_in;
   logic                                 advance, busy, needs_esc, emit, consumed;

   always_comb begin
      advance = !rsp_valid_ff || !rsp_stall;
      busy = remain_ff != '0;
      needs_esc = !raw_ff[0] && (bytes_ff[0] inside {rrf_pkg::EscByte, rrf_pkg::StartByte,
                                                     rrf_pkg::MarkC2Byte});
      emit = advance && busy;
      consumed = emit && (!needs_esc || phase_ff);
      take = batch_valid && advance && (!busy || (consumed && remain_ff == 4'd1));

      if (phase_ff) begin
         rsp_in.out_byte = bytes_ff[0] - rrf_pkg::EscByte;
      end else if (needs_esc) begin
         rsp_in.out_byte = rrf_pkg::EscByte;
      end else begin
         rsp_in.out_byte = bytes_ff[0];
      end
      rsp_in.frame_last = end_ff && remain_ff == 4'd1 && (!needs_esc || phase_ff);

      rsp_valid_in = advance ? busy : rsp_valid_ff;
      phase_in = emit ? (needs_esc && !phase_ff) : phase_ff;

      bytes_in = bytes_ff;
      raw_in = raw_ff;
      remain_in = remain_ff;
      end_in = end_ff;
      if (take) begin
         bytes_in = batch.bytes;
         raw_in = batch.raw;
         remain_in = batch.count;
         end_in = batch.end_frame;
      end else if (consumed) begin
         bytes_in = bytes_ff >> 8;
         raw_in = raw_ff >> 1;
         remain_in = remain_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         remain_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         remain_ff <= remain_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      raw_ff <= raw_in;
      end_ff <= end_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_phase_busy: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> remain_ff != '0)
      else $error("escape pending with no byte left");

   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> !raw_ff[0] && (bytes_ff[0] == rrf_pkg::EscByte ||
                                  bytes_ff[0] == rrf_pkg::StartByte ||
                                  bytes_ff[0] == rrf_pkg::MarkC2Byte))
      else $error("escape pending on a byte that needs none");

   a_remain_range: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= 4'd8)
      else $error("slot count out of range");

endmodule

// ----- rtl/core/rs485_request_framer.sv -----
// Channel   Direction  Handshake          Content
// req_      in         req_valid/stall    one body byte plus frame start/end and header fields
// rsp_      out        rsp_valid/stall    one escaped line byte, frame_last on final CRC byte
// csr_      in         csr_valid/ready    register index and write data
//
// A request produces one line byte per cycle while the response is not stalled:
// a plain body byte becomes one line byte, an escaped one two; a frame-start
// request adds the start byte and the header, and a frame-end request the CRC,
// so a request yields 0 to 15 bytes; the emitter's single-byte output sets the rate.
// Reset is synchronous; afterwards no frame is open and both header registers are 0.
// A stalled response holds; one decoded request waits in the builder while the
// emitter drains the previous one, so requests stall only when both are occupied.
module rs485_request_framer (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  rrf_pkg::req_type  req_payload,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rrf_pkg::rsp_type  rsp_payload,

   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [7:0]        csr_data
);

   // Header registers. Writes to indexes beyond the list are dropped.
   logic [7:0] device_type_ff, device_type_in;
   logic [7:0] line_address_ff, line_address_in;

   logic               accept;
   logic               take;
   logic               batch_valid;
   rrf_pkg::batch_type batch;

   // The port never pushes back on register writes.
   assign csr_ready = 1'b1;

   always_comb begin
      device_type_in = device_type_ff;
      line_address_in = line_address_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rrf_pkg::CsrDeviceType: begin
               device_type_in = csr_data;
            end
            rrf_pkg::CsrLineAddress: begin
               line_address_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_type_ff <= 8'h00;
         line_address_ff <= 8'h00;
      end else begin
         device_type_ff <= device_type_in;
         line_address_ff <= line_address_in;
      end
   end

   // The builder can take a new request whenever its batch register is free or
   // is being handed to the emitter in this same cycle.
   assign req_stall = batch_valid && !take;
   assign accept = req_valid && !req_stall;

   // The builder folds the request into the running CRC and lays out the
   // unescaped bytes it contributes to the frame.
   rrf_builder u_builder (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_payload  (req_payload),
      .device_type  (device_type_ff),
      .line_address (line_address_ff),
      .take         (take),
      .batch_valid  (batch_valid),
      .batch        (batch)
   );

   // The emitter walks the batch one line byte per cycle while rsp_stall is low,
   // sending C0, C1 and C2 as escape byte plus offset, everywhere but on the start byte.
   rrf_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .batch_valid (batch_valid),
      .batch       (batch),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- tb/rrf_checker.sv -----
module rrf_checker
   import rrf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_payload,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_payload,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data,

   output int unsigned failures,
   output int unsigned pending
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PrintLimit = 100;

   logic [7:0]  device_type_q = '0;
   logic [7:0]  line_address_q = '0;
   logic [15:0] frame_crc = CrcInit;
   logic        frame_open = 1'b0;
   rsp_type     line_bytes_due[$];
   int unsigned mismatch_count = 0;

   assign failures = mismatch_count;

   // Reflected CRC-16, one message bit per step, low bit first.
   function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         r = (r[0] ^ b[k]) ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      end
      return r;
   endfunction

   function automatic void queue_line_byte(input logic [7:0] b, input logic last);
      rsp_type e;
      e.out_byte = b;
      e.frame_last = last;
      line_bytes_due.push_back(e);
   endfunction

   // Bytes C0, C1 and C2 go out as the escape byte followed by their offset.
   function automatic void queue_escaped(input logic [7:0] b, input logic last);
      if (b == EscByte || b == StartByte || b == MarkC2Byte) begin
         queue_line_byte(EscByte, 1'b0);
         queue_line_byte(b - EscByte, last);
      end else begin
         queue_line_byte(b, last);
      end
   endfunction

   function automatic void queue_body_byte(input logic [7:0] b);
      frame_crc = crc16_fold(frame_crc, b);
      queue_escaped(b, 1'b0);
   endfunction

   function automatic void predict_request(input req_type r);
      if (r.frame_start) begin
         frame_open = 1'b1;
         frame_crc = crc16_fold(CrcInit, StartByte);
         queue_line_byte(StartByte, 1'b0);
         queue_body_byte(device_type_q);
         queue_body_byte(line_address_q);
         queue_body_byte(r.service_byte);
         queue_body_byte(r.body_length);
      end else if (!frame_open) begin
         return;
      end
      queue_body_byte(r.data_byte);
      if (r.frame_end) begin
         queue_escaped(frame_crc[7:0], 1'b0);
         queue_escaped(frame_crc[15:8], 1'b1);
         frame_open = 1'b0;
         frame_crc = CrcInit;
      end
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PrintLimit) begin
         $display("%0t ns rsp mismatch: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      if (reset) begin
         device_type_q = '0;
         line_address_q = '0;
         frame_crc = CrcInit;
         frame_open = 1'b0;
         line_bytes_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CsrDeviceType) begin
               device_type_q = csr_data;
            end else if (csr_index == CsrLineAddress) begin
               line_address_q = csr_data;
            end
         end
         if (req_valid && !req_stall) begin
            predict_request(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (line_bytes_due.size() == 0) begin
               report_mismatch($sformatf("byte %h last %b with nothing expected",
                                         got.out_byte, got.frame_last));
            end else begin
               want = line_bytes_due.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            got.out_byte, want.out_byte));
               end
               if (got.frame_last !== want.frame_last) begin
                  report_mismatch($sformatf("frame_last %b, expected %b on byte %h",
                                            got.frame_last, want.frame_last, want.out_byte));
               end
            end
         end
      end
      pending <= line_bytes_due.size();
   end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import rrf_pkg::*;

   // Number of random requests that carry frame content.
   localparam int unsigned RandomItems = 220;
   // Cycles the framer is given to finish after the last expected byte; a request
   // yields at most 15 line bytes and one more request can sit in the builder.
   localparam int unsigned DrainCycles = 40;
   // Length of the one long receiver hold-off that fills the framer.
   localparam int unsigned HoldCycles = 400;
   // Cycles without any handshake before the run is declared hung.
   localparam int unsigned WatchdogLimit = 4000;
   // An index past the two header registers; writes to it must be dropped.
   localparam logic [7:0] CsrUnmapped = 8'hFF;

   logic        clock;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   int unsigned failures;
   int unsigned pending;

   // Knobs shared by the request driver and the response stall process, plus counters.
   logic        no_idle = 1'b0;
   logic        hold_request = 1'b0;
   int unsigned sent_count = 0;
   int unsigned quiet_cycles = 0;

   rs485_request_framer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // The checker sees every handshake, predicts the line bytes and counts mismatches.
   rrf_checker u_checker (.*);

   // 12 ns clock, low half first.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // The watchdog restarts on any handshake. A correct run never goes quiet for
   // more than the long hold-off or a drain pause, both far below the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The response side stalls in about a quarter of the cycles. When the stimulus
   // asks for it, it holds off once for a long stretch so the framer backs up into
   // the request channel. During the quiet stretch it never stalls.
   initial begin : rsp_side
      int unsigned held;
      bit          hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            for (held = 0; held < HoldCycles; held++) begin
               @(negedge clock);
            end
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 23);
         end
      end
   end

   // Payload bytes lean toward the three escaped values so escaping is busy.
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(3) == 0) begin
         return EscByte + 8'($urandom_range(2));
      end
      return 8'($urandom);
   endfunction

   // Offers one request and returns after the edge that accepts it. Idle gaps are
   // inserted in front, never while the request is stalled, so a stalled payload
   // holds still.
   task automatic send_request(input logic [7:0] data, input logic start, input logic last,
                               input logic [7:0] service, input logic [7:0] length);
      req_type r;
      r.data_byte = data;
      r.frame_start = start;
      r.frame_end = last;
      r.service_byte = service;
      r.body_length = length;
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Register writes only happen with the framer idle: every expected byte has
   // come out, then a pause covers anything still inside from ignored requests.
   task automatic write_register(input logic [7:0] index, input logic [7:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (DrainCycles) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One frame: a command request, then the parameter bytes. A closed frame marks
   // its last byte as frame end; with no parameters start and end share a request.
   // An unclosed frame is left open for the next start to abandon.
   task automatic send_frame(input int unsigned params, input bit closed);
      logic [7:0] length;
      if ($urandom_range(1) == 0) begin
         length = (params < 254) ? 8'(params + 1) : 8'd255;
      end else begin
         length = 8'($urandom_range(255, 1));
      end
      send_request(pick_byte(), 1'b1, closed && params == 0, pick_byte(), length);
      for (int unsigned p = 0; p < params; p++) begin
         send_request(pick_byte(), 1'b0, closed && p == params - 1, pick_byte(), pick_byte());
      end
      sent_count += params + 1;
   endtask

   initial begin : stimulus
      int unsigned roll;
      int unsigned params;
      int unsigned quiet_from;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, with both header registers still at their reset value.
      // A byte before any frame is open is dropped, even with frame end set.
      send_request(StartByte, 1'b0, 1'b1, 8'h00, 8'h01);
      // Start and end on the same request: a one-byte body, header and CRC at once.
      send_request(8'h00, 1'b1, 1'b1, 8'hFF, 8'h01);
      // The first three body bytes and the service byte need escaping; the length is the largest.
      send_request(EscByte, 1'b1, 1'b0, StartByte, 8'hFF);
      send_request(StartByte, 1'b0, 1'b0, 8'h00, 8'h00);
      send_request(MarkC2Byte, 1'b0, 1'b0, 8'hFF, 8'hFF);
      send_request(8'hFF, 1'b0, 1'b0, 8'h55, 8'hAA);
      send_request(8'hBF, 1'b0, 1'b1, 8'hAA, 8'h55);
      // A new start inside an open frame drops the open one without a CRC.
      send_request(8'h12, 1'b1, 1'b0, 8'h34, 8'h03);
      send_request(8'h56, 1'b0, 1'b0, 8'h00, 8'h00);
      send_request(8'h78, 1'b1, 1'b0, MarkC2Byte, 8'h02);
      send_request(8'h9A, 1'b0, 1'b1, 8'h00, 8'h00);
      // Closed again, so this one is ignored too.
      send_request(8'hFF, 1'b0, 1'b0, 8'hFF, 8'hFF);

      // All-ones device type, an escaped address, and a write to an unmapped index
      // that must leave both registers alone.
      write_register(CsrDeviceType, 8'hFF);
      write_register(CsrLineAddress, StartByte);
      write_register(CsrUnmapped, 8'h00);
      send_request(8'hFF, 1'b1, 1'b1, 8'h00, 8'h80);

      write_register(CsrDeviceType, MarkC2Byte);
      write_register(CsrLineAddress, EscByte);
      write_register(CsrUnmapped, 8'hFF);
      send_request(StartByte, 1'b1, 1'b0, EscByte, MarkC2Byte);
      send_request(8'h00, 1'b0, 1'b1, 8'h01, 8'h7F);

      // Random part in three phases, each with its own header settings. The second
      // phase opens with the long receiver hold-off; the third has a stretch with
      // no idling on either side.
      for (int unsigned phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               write_register(CsrDeviceType, 8'($urandom));
               write_register(CsrLineAddress, 8'($urandom));
            end
            1: begin
               write_register(CsrDeviceType, 8'hFF);
               write_register(CsrLineAddress, 8'hFF);
               hold_request = 1'b1;
            end
            default: begin
               write_register(CsrDeviceType, pick_byte());
               write_register(CsrLineAddress, 8'h00);
            end
         endcase
         quiet_from = sent_count;
         while (sent_count < (phase + 1) * RandomItems / 3) begin
            no_idle = (phase == 2) && (sent_count - quiet_from < 50);
            roll = $urandom_range(99);
            params = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(5);
            if (roll < 80) begin
               send_frame(params, 1'b1);
            end else if (roll < 88) begin
               // A stray byte: dropped if no frame is open, a body byte otherwise.
               send_request(pick_byte(), 1'b0, 1'($urandom_range(1)), pick_byte(),
                            pick_byte());
            end else begin
               send_frame(params, 1'b0);
            end
         end
         no_idle = 1'b0;
      end

      // Wait for the last expected byte, then give the framer time to show any
      // byte it should not send.
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/rrf_pkg.sv
rtl/core/rrf_builder.sv
rtl/core/rrf_emitter.sv
rtl/core/rs485_request_framer.sv
tb/rrf_checker.sv
tb/tb_top.sv
